@@ design/sdgr_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed decimal glyph renderer package
// Shared widths, display command codes, glyph tables and the status record
// that the serial divide-by-ten unit hands to the top level.
// ----------------------------------------------------------------------------
package sdgr_pkg;

  localparam int VALUE_W = 16;
  localparam int COL_W   = 7;
  localparam int DIGIT_W = 4;

  // Display controller address commands
  localparam logic [7:0] PAGE_CMD     = 8'hB7;
  localparam logic [7:0] COL_LOW_CMD  = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD = 8'h12;

  // Rightmost usable column and reset value of the start column
  localparam logic [COL_W-1:0] COL_MAX      = 7'd101;
  localparam logic [COL_W-1:0] RESET_COLUMN = 7'd80;

  // Divisor of the digit extraction
  localparam logic [DIGIT_W:0] RADIX = 5'd10;

  // Result of one division step sequence
  typedef struct packed {
    logic                 done;
    logic [DIGIT_W-1:0]   digit;
    logic [VALUE_W-1:0]   quot;
  } div_out_t;

  // Column idx of the glyph of a decimal digit; codes above nine are blank.
  function automatic logic [7:0] digit_glyph(input logic [DIGIT_W-1:0] digit,
                                             input logic [1:0] idx);
    logic [31:0] cols;
    cols = 32'h0;
    unique case (digit)
      4'd0:    cols = 32'h007F417F;
      4'd1:    cols = 32'h0004027F;
      4'd2:    cols = 32'h0079494F;
      4'd3:    cols = 32'h0049497F;
      4'd4:    cols = 32'h000F087F;
      4'd5:    cols = 32'h004F4979;
      4'd6:    cols = 32'h007F4979;
      4'd7:    cols = 32'h0003710F;
      4'd8:    cols = 32'h007F497F;
      4'd9:    cols = 32'h004F497F;
      default: cols = 32'h0;
    endcase
    return cols[8*idx +: 8];
  endfunction

  // Column idx of the sign glyph: minus when negative, plus otherwise.
  function automatic logic [7:0] sign_glyph(input logic negative,
                                            input logic [1:0] idx);
    logic [31:0] cols;
    cols = negative ? 32'h00080808 : 32'h00081C08;
    return cols[8*idx +: 8];
  endfunction

endpackage

@@ design/signed_decimal_glyph_renderer.sv @@
// ----------------------------------------------------------------------------
// Signed decimal glyph renderer
// Turns a signed 16-bit number into display controller address commands and
// glyph columns, least significant digit first, followed by the sign glyph.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one signed value per transfer in s_tdata. The
//   master stream sends one byte per transfer: m_tuser is high on address
//   commands, m_tlast marks the final column of the sign glyph. For every
//   digit and for the sign, three commands (page, column low nibble, column
//   high nibble) precede GLYPH_WIDTH glyph columns.
//   The cfg channel writes start_column; it is ready whenever reset is low
//   and must only be written while no value is in progress.
// Sequencing:
//   Each digit takes 16 shift steps of a serial divide-by-ten unit before its
//   glyph is sent. One value is handled at a time; s_tready is high only
//   while idle and out of reset.
// Reset and stalls:
//   Reset drops any value in progress, empties the output register and sets
//   start_column to 80. While m_tvalid is high and m_tready is low the output
//   byte holds and the sequencer waits.
// ----------------------------------------------------------------------------
module signed_decimal_glyph_renderer #(
  parameter int GLYPH_WIDTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write: start_column
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sdgr_pkg::COL_W-1:0]           cfg_data,
  // Input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic signed [sdgr_pkg::VALUE_W-1:0]  s_tdata,   // [15:0] value
  // Output stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,   // [7:0] out_byte
  output logic                                 m_tuser,   // [0] is_command
  output logic                                 m_tlast    // last_byte
);

  // Step counter covers three commands and the glyph columns.
  localparam int STEP_W = $clog2(GLYPH_WIDTH + 3);
  localparam int ACC_W  = $clog2(128 + GLYPH_WIDTH * 6);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GLYPH_WIDTH + 2);
  localparam logic [STEP_W-1:0] CMD_STEPS = STEP_W'(3);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                          state;
  logic [sdgr_pkg::COL_W-1:0]      start_column;
  logic                            negative;
  logic                            doing_sign;
  logic [ACC_W-1:0]                col_acc;
  logic [STEP_W-1:0]               step;

  logic                            accept;
  logic                            emit_fire;
  logic                            div_start;
  logic [sdgr_pkg::VALUE_W-1:0]    magnitude;
  logic [sdgr_pkg::VALUE_W-1:0]    dividend;
  sdgr_pkg::div_out_t              div_res;
  logic [sdgr_pkg::COL_W-1:0]      col;
  logic [STEP_W-1:0]               glyph_off;
  logic [7:0]                      glyph_byte;
  logic [7:0]                      byte_next;
  logic                            cmd_next;
  logic                            last_next;

  assign cfg_ready = !rst;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign emit_fire = (state == S_EMIT) && (!m_tvalid || m_tready);

  // Magnitude of the input; the most negative value maps to 0x8000.
  assign magnitude = s_tdata[sdgr_pkg::VALUE_W-1]
                     ? sdgr_pkg::VALUE_W'(~s_tdata + 1'b1)
                     : sdgr_pkg::VALUE_W'(s_tdata);

  // A new division starts on accept or after a digit whose quotient is nonzero.
  always_comb begin
    div_start = 1'b0;
    dividend  = div_res.quot;
    if (accept) begin
      div_start = 1'b1;
      dividend  = magnitude;
    end else if (emit_fire && (step == LAST_STEP) && !doing_sign &&
                 (div_res.quot != '0)) begin
      div_start = 1'b1;
    end
  end

  sdgr_div10 u_div10 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .result   (div_res)
  );

  // Clamped column of the current glyph.
  assign col = (col_acc > ACC_W'(sdgr_pkg::COL_MAX)) ? sdgr_pkg::COL_MAX
                                                     : sdgr_pkg::COL_W'(col_acc);

  // Glyph column lookup; columns past the fourth are blank.
  always_comb begin
    glyph_off = step - CMD_STEPS;
    if (32'(glyph_off) >= 32'd4) begin
      glyph_byte = 8'h00;
    end else if (doing_sign) begin
      glyph_byte = sdgr_pkg::sign_glyph(negative, glyph_off[1:0]);
    end else begin
      glyph_byte = sdgr_pkg::digit_glyph(div_res.digit, glyph_off[1:0]);
    end
  end

  // Byte for the current step.
  always_comb begin
    cmd_next  = 1'b1;
    last_next = 1'b0;
    priority if (step == STEP_W'(0)) begin
      byte_next = sdgr_pkg::PAGE_CMD;
    end else if (step == STEP_W'(1)) begin
      byte_next = sdgr_pkg::COL_LOW_CMD + {4'h0, col[3:0]};
    end else if (step == STEP_W'(2)) begin
      byte_next = sdgr_pkg::COL_HIGH_CMD + {5'h0, col[6:4]};
    end else begin
      byte_next = glyph_byte;
      cmd_next  = 1'b0;
      last_next = doing_sign && (step == LAST_STEP);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_column <= sdgr_pkg::RESET_COLUMN;
    end else if (cfg_valid && cfg_ready) begin
      start_column <= cfg_data;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      doing_sign <= 1'b0;
      step       <= '0;
    end else begin
      // Output valid: set by each new byte, cleared once the byte is taken.
      if (emit_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            negative   <= s_tdata[sdgr_pkg::VALUE_W-1];
            col_acc    <= ACC_W'(start_column);
            doing_sign <= 1'b0;
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            step  <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            m_tdata  <= byte_next;
            m_tuser  <= cmd_next;
            m_tlast  <= last_next;
            if (step == LAST_STEP) begin
              step    <= '0;
              col_acc <= col_acc + ACC_W'(GLYPH_WIDTH);
              if (doing_sign) begin
                state <= S_IDLE;
              end else if (div_res.quot == '0) begin
                doing_sign <= 1'b1;
              end else begin
                state <= S_DIV;
              end
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/sdgr_div10.sv @@
// ----------------------------------------------------------------------------
// Serial divide-by-ten unit
// Restoring division of a 16-bit unsigned value by ten, one quotient bit per
// cycle. The remainder is the next decimal digit.
// ----------------------------------------------------------------------------
module sdgr_div10 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sdgr_pkg::VALUE_W-1:0]  dividend,
  output sdgr_pkg::div_out_t            result
);

  localparam int CNT_W = $clog2(sdgr_pkg::VALUE_W);

  logic                          running;
  logic                          done;
  logic [CNT_W-1:0]              cnt;
  logic [sdgr_pkg::VALUE_W-1:0]  quot;
  logic [sdgr_pkg::DIGIT_W-1:0]  rem;

  logic [sdgr_pkg::DIGIT_W:0]    trial;
  logic                          fits;
  logic [sdgr_pkg::DIGIT_W-1:0]  rem_next;

  // One trial subtraction: bring down the next dividend bit.
  always_comb begin
    trial    = {rem, quot[sdgr_pkg::VALUE_W-1]};
    fits     = (trial >= sdgr_pkg::RADIX);
    rem_next = fits ? sdgr_pkg::DIGIT_W'(trial - sdgr_pkg::RADIX)
                    : sdgr_pkg::DIGIT_W'(trial);
  end

  // Control: count sixteen steps and pulse done after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CNT_W'(sdgr_pkg::VALUE_W - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(sdgr_pkg::VALUE_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (running) begin
      quot <= {quot[sdgr_pkg::VALUE_W-2:0], fits};
      rem  <= rem_next;
    end
  end

  assign result.done  = done;
  assign result.digit = rem;
  assign result.quot  = quot;

endmodule
